/* design/prht_pkg.sv */
// Package for the prompt handoff retransmit tracker.
// Holds request/response payload types, register index codes and reset constants.
// No dependencies.
package prht_pkg;

  localparam int unsigned IndexWidthDefault = 32;
  localparam int unsigned TimeWidthDefault  = 64;

  localparam int unsigned FieldWidth  = 32;
  localparam int unsigned StampWidth  = 64;
  localparam int unsigned CfgIdxWidth = 2;

  localparam logic [FieldWidth-1:0] PollIntervalReset = 32'd20000000;
  localparam logic [FieldWidth-1:0] RegrantFastReset  = 32'd100000000;
  localparam logic [FieldWidth-1:0] RegrantIdleReset  = 32'd1000000000;

  typedef enum logic {
    OpPoll    = 1'b0,
    OpPublish = 1'b1
  } op_e;

  typedef enum logic [CfgIdxWidth-1:0] {
    CfgPollInterval = 2'd0,
    CfgRegrantFast  = 2'd1,
    CfgRegrantIdle  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic                  operation;
    logic [StampWidth-1:0] now_time;
    logic                  prompt_empty;
    logic [FieldWidth-1:0] enc_frames_in;
    logic [FieldWidth-1:0] audio_samples_in;
    logic [FieldWidth-1:0] peer_ack_index;
    logic [FieldWidth-1:0] peer_rx_index;
  } prht_req_t;

  typedef struct packed {
    logic                  send_handoff;
    logic [FieldWidth-1:0] handoff_index;
    logic [FieldWidth-1:0] handoff_enc_frames;
    logic [FieldWidth-1:0] handoff_audio_samples;
    logic                  answered;
    logic [FieldWidth-1:0] publish_index;
    logic                  busy_res;
    logic                  received_seen;
    logic [FieldWidth-1:0] regrant_total;
    logic [StampWidth-1:0] answer_latency;
  } prht_rsp_t;

endpackage

/* design/prht_in_reg.sv */
// Input register stage of the tracker: holds one request until the core takes it.
// Depends on prht_pkg for the request payload type.
module prht_in_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  prht_pkg::prht_req_t req_i,
  output logic                valid_o,
  input  logic                ready_i,
  output prht_pkg::prht_req_t req_o
);
  import prht_pkg::*;

  logic      valid_q;
  prht_req_t req_q;

  // Take a new request when empty or whenever the held one leaves in the same cycle.
  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign req_o   = req_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      req_q <= req_i;
    end
  end

endmodule

/* design/prht_core.sv */
// Tracker state, configuration registers and the combinational update for one request.
// Depends on prht_pkg for payload types, register codes and reset values.
module prht_core #(
  parameter int unsigned INDEX_WIDTH = prht_pkg::IndexWidthDefault,
  parameter int unsigned TIME_WIDTH  = prht_pkg::TimeWidthDefault
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [prht_pkg::CfgIdxWidth-1:0]     cfg_index_i,
  input  logic [prht_pkg::FieldWidth-1:0]      cfg_data_i,
  input  logic                                 fire_i,
  input  prht_pkg::prht_req_t                  req_i,
  output prht_pkg::prht_rsp_t                  rsp_o
);
  import prht_pkg::*;

  logic [FieldWidth-1:0]  poll_interval_q, regrant_fast_q, regrant_idle_q;

  logic [INDEX_WIDTH-1:0] idx_q, idx_d;
  logic                   pending_q, pending_d;
  logic                   receipt_q, receipt_d;
  logic [TIME_WIDTH-1:0]  sent_q, sent_d;
  logic [TIME_WIDTH-1:0]  last_poll_q, last_poll_d;
  logic [TIME_WIDTH-1:0]  last_regrant_q, last_regrant_d;
  logic [FieldWidth-1:0]  regrant_q, regrant_d;
  logic [FieldWidth-1:0]  enc_q, enc_d;
  logic [FieldWidth-1:0]  aud_q, aud_d;

  logic [TIME_WIDTH-1:0]  now;
  logic [INDEX_WIDTH-1:0] ack, rx;
  logic [TIME_WIDTH-1:0]  poll_diff, regrant_diff;
  logic [FieldWidth-1:0]  window;
  logic                   publish, poll_ok, ack_hit, rx_hit, rcpt_next, regrant_hit;
  logic                   send, answered;

  assign now = req_i.now_time[TIME_WIDTH-1:0];
  assign ack = req_i.peer_ack_index[INDEX_WIDTH-1:0];
  assign rx  = req_i.peer_rx_index[INDEX_WIDTH-1:0];

  assign publish   = (op_e'(req_i.operation) == OpPublish) && !req_i.prompt_empty;
  assign poll_diff = now - last_poll_q;
  assign poll_ok   = (op_e'(req_i.operation) == OpPoll) && pending_q &&
                     (poll_diff >= TIME_WIDTH'(poll_interval_q));
  assign ack_hit   = ack >= idx_q;
  assign rx_hit    = !receipt_q && (rx >= idx_q);
  assign rcpt_next = receipt_q || rx_hit;
  assign window    = rcpt_next ? regrant_idle_q : regrant_fast_q;
  // Fresh receipt restamps the regrant time to now, so the elapsed time is zero.
  assign regrant_diff = rx_hit ? '0 : (now - last_regrant_q);
  assign regrant_hit  = regrant_diff >= TIME_WIDTH'(window);

  always_comb begin
    idx_d          = idx_q;
    pending_d      = pending_q;
    receipt_d      = receipt_q;
    sent_d         = sent_q;
    last_poll_d    = last_poll_q;
    last_regrant_d = last_regrant_q;
    regrant_d      = regrant_q;
    enc_d          = enc_q;
    aud_d          = aud_q;
    send           = 1'b0;
    answered       = 1'b0;
    if (publish) begin
      idx_d          = idx_q + INDEX_WIDTH'(1);
      enc_d          = req_i.enc_frames_in;
      aud_d          = req_i.audio_samples_in;
      pending_d      = 1'b1;
      receipt_d      = 1'b0;
      regrant_d      = '0;
      sent_d         = now;
      last_poll_d    = now;
      last_regrant_d = now;
      send           = 1'b1;
    end else if (poll_ok) begin
      last_poll_d = now;
      if (ack_hit) begin
        pending_d = 1'b0;
        answered  = 1'b1;
      end else begin
        receipt_d = rcpt_next;
        if (rx_hit) begin
          last_regrant_d = now;
        end
        if (regrant_hit) begin
          last_regrant_d = now;
          regrant_d      = regrant_q + FieldWidth'(1);
          send           = 1'b1;
        end
      end
    end
  end

  always_comb begin
    rsp_o                       = '0;
    rsp_o.send_handoff          = send;
    rsp_o.handoff_index         = send ? FieldWidth'(idx_d) : '0;
    rsp_o.handoff_enc_frames    = send ? enc_d : '0;
    rsp_o.handoff_audio_samples = send ? aud_d : '0;
    rsp_o.answered              = answered;
    rsp_o.publish_index         = publish ? FieldWidth'(idx_d) : '0;
    rsp_o.busy_res              = pending_d;
    rsp_o.received_seen         = receipt_d;
    rsp_o.regrant_total         = regrant_d;
    rsp_o.answer_latency        = answered ? StampWidth'(now - sent_q) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poll_interval_q <= PollIntervalReset;
      regrant_fast_q  <= RegrantFastReset;
      regrant_idle_q  <= RegrantIdleReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgPollInterval: poll_interval_q <= cfg_data_i;
        CfgRegrantFast:  regrant_fast_q  <= cfg_data_i;
        CfgRegrantIdle:  regrant_idle_q  <= cfg_data_i;
        default: ;  // drop writes to unmapped indexes
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q          <= '0;
      pending_q      <= 1'b0;
      receipt_q      <= 1'b0;
      sent_q         <= '0;
      last_poll_q    <= '0;
      last_regrant_q <= '0;
      regrant_q      <= '0;
      enc_q          <= '0;
      aud_q          <= '0;
    end else if (fire_i) begin
      idx_q          <= idx_d;
      pending_q      <= pending_d;
      receipt_q      <= receipt_d;
      sent_q         <= sent_d;
      last_poll_q    <= last_poll_d;
      last_regrant_q <= last_regrant_d;
      regrant_q      <= regrant_d;
      enc_q          <= enc_d;
      aud_q          <= aud_d;
    end
  end

  a_publish_arms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && publish |=> pending_q && !receipt_q && (regrant_q == '0) && (sent_q == $past(now)))
    else $error("publish did not arm a fresh request");

  a_idle_poll_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && (op_e'(req_i.operation) == OpPoll) && !pending_q |->
      !rsp_o.send_handoff && !rsp_o.answered)
    else $error("poll while idle produced activity");

  a_answer_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && rsp_o.answered |=> !pending_q && (idx_q == $past(idx_q)))
    else $error("answered request still pending");

endmodule

/* design/prht_out_reg.sv */
// Result register stage of the tracker: holds one response until the consumer takes it.
// Depends on prht_pkg for the response payload type.
module prht_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  output logic                ready_o,
  input  prht_pkg::prht_rsp_t rsp_i,
  output logic                valid_o,
  input  logic                ready_i,
  output prht_pkg::prht_rsp_t rsp_o
);
  import prht_pkg::*;

  logic      valid_q;
  prht_rsp_t rsp_q;

  // Free when empty or when the held response is taken this cycle.
  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign rsp_o   = rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rsp_q <= rsp_i;
    end
  end

endmodule

/* design/prompt_handoff_retransmit_tracker.sv */
// Stop-and-wait handoff tracker: one result per request, one request per cycle sustained.
// A request passes an input register, updates the tracker state combinationally and lands
// in a result register, which presents its result; the pipe keeps full throughput while
// the consumer stays ready. Depends on prht_pkg, prht_in_reg, prht_core and prht_out_reg.
module prompt_handoff_retransmit_tracker #(
  parameter int unsigned INDEX_WIDTH = prht_pkg::IndexWidthDefault,
  parameter int unsigned TIME_WIDTH  = prht_pkg::TimeWidthDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  prht_pkg::prht_req_t              in_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output prht_pkg::prht_rsp_t              out_o,
  input  logic                             cfg_we_i,
  input  logic [prht_pkg::CfgIdxWidth-1:0] cfg_index_i,
  input  logic [prht_pkg::FieldWidth-1:0]  cfg_data_i
);
  import prht_pkg::*;

  logic      s1_valid, out_free, fire;
  prht_req_t s1_req;
  prht_rsp_t core_rsp;

  assign fire = s1_valid && out_free;

  prht_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .req_i   (in_i),
    .valid_o (s1_valid),
    .ready_i (out_free),
    .req_o   (s1_req)
  );

  prht_core #(
    .INDEX_WIDTH (INDEX_WIDTH),
    .TIME_WIDTH  (TIME_WIDTH)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .fire_i      (fire),
    .req_i       (s1_req),
    .rsp_o       (core_rsp)
  );

  prht_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (fire),
    .ready_o (out_free),
    .rsp_i   (core_rsp),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .rsp_o   (out_o)
  );

endmodule
